// ===== hw/rtl/mrf_pkg.sv =====
`default_nettype none
package mrf_pkg;

    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int STATE_W = 4;

    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_SEED = 16'hFFFF;
    localparam logic [BYTE_W-1:0] SLAVE_ADDR_RESET = 8'd1;
    // A write frame body is four bytes; the first one loads this count.
    localparam logic [BYTE_W-1:0] WRITE_BYTES_LEFT = 8'd3;

    typedef struct packed {
        logic [STATE_W-1:0] frame_state;
        logic               frame_complete;
        logic               crc_error;
        logic               is_exception;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/mrf_rx_if.sv =====
`default_nettype none
interface mrf_rx_if;
    logic                      valid;
    logic                      ready;
    logic [mrf_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mrf_res_if.sv =====
`default_nettype none
interface mrf_res_if;
    logic                        valid;
    logic                        ready;
    logic [mrf_pkg::STATE_W-1:0] frame_state;
    logic                        frame_complete;
    logic                        crc_error;
    logic                        is_exception;

    modport source (output valid, output frame_state, output frame_complete,
                    output crc_error, output is_exception, input ready);
    modport sink   (input valid, input frame_state, input frame_complete,
                    input crc_error, input is_exception, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mrf_crc.sv =====
`default_nettype none
module mrf_crc (
    input  wire logic [mrf_pkg::CRC_W-1:0]  i_crc,
    input  wire logic [mrf_pkg::BYTE_W-1:0] i_byte,
    output logic      [mrf_pkg::CRC_W-1:0]  o_crc
);

    // Reflected CRC-16, one bit of the byte per step.
    always_comb begin
        logic [mrf_pkg::CRC_W-1:0] c;
        c = i_crc ^ {{(mrf_pkg::CRC_W - mrf_pkg::BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < mrf_pkg::BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mrf_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mrf_fsm.sv =====
`default_nettype none
module mrf_fsm (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [mrf_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic [mrf_pkg::BYTE_W-1:0]  i_slave_address,
    output mrf_pkg::t_result                 o_result
);

    typedef enum logic [mrf_pkg::STATE_W-1:0] {
        ST_WAIT       = 4'd0,
        ST_ADDR       = 4'd1,
        ST_EXC_FUNC   = 4'd2,
        ST_EXC_CODE   = 4'd3,
        ST_READ_FUNC  = 4'd4,
        ST_WRITE_FUNC = 4'd5,
        ST_PAYLOAD    = 4'd6,
        ST_LAST       = 4'd7,
        ST_CRC_LOW    = 4'd8,
        ST_COMPLETE   = 4'd9
    } t_state;

    t_state                      r_state, n_state;
    logic [mrf_pkg::BYTE_W-1:0]  r_bytes_left, n_bytes_left;
    logic [mrf_pkg::CRC_W-1:0]   r_crc, n_crc;
    logic [mrf_pkg::BYTE_W-1:0]  r_crc_low, n_crc_low;
    logic                        r_exc, n_exc;
    mrf_pkg::t_result            r_result, n_result;

    logic                        in_body;
    logic [mrf_pkg::CRC_W-1:0]   crc_in, crc_out;
    logic [3:0]                  nib;
    logic                        done, err;

    // Outside a frame the CRC restarts from the seed on the address byte.
    always_comb begin
        in_body = (r_state == ST_ADDR) || (r_state == ST_EXC_FUNC) ||
                  (r_state == ST_READ_FUNC) || (r_state == ST_WRITE_FUNC) ||
                  (r_state == ST_PAYLOAD);
        crc_in  = in_body ? r_crc : mrf_pkg::CRC_SEED;
    end

    mrf_crc u_crc (
        .i_crc  (crc_in),
        .i_byte (i_byte),
        .o_crc  (crc_out)
    );

    assign nib = i_byte[3:0];

    always_comb begin
        n_state      = r_state;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_crc_low    = r_crc_low;
        n_exc        = r_exc;
        done         = 1'b0;
        err          = 1'b0;
        case (r_state)
            ST_ADDR: begin
                n_crc = crc_out;
                n_exc = 1'b0;
                if (i_byte[7]) begin
                    n_exc   = 1'b1;
                    n_state = ST_EXC_FUNC;
                end else if (nib inside {[4'd1:4'd4]}) begin
                    n_state = ST_READ_FUNC;
                end else if (nib inside {4'd0, 4'd5, 4'd6, 4'd15}) begin
                    n_state = ST_WRITE_FUNC;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_EXC_FUNC: begin
                n_crc   = crc_out;
                n_state = ST_EXC_CODE;
            end
            ST_EXC_CODE, ST_LAST: begin
                n_crc_low = i_byte;
                n_state   = ST_CRC_LOW;
            end
            ST_READ_FUNC: begin
                n_crc        = crc_out;
                n_bytes_left = i_byte;
                n_state      = (i_byte == '0) ? ST_LAST : ST_PAYLOAD;
            end
            ST_WRITE_FUNC: begin
                n_crc        = crc_out;
                n_bytes_left = mrf_pkg::WRITE_BYTES_LEFT;
                n_state      = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                n_crc        = crc_out;
                n_bytes_left = r_bytes_left - 1'b1;
                if (n_bytes_left == '0) begin
                    n_state = ST_LAST;
                end
            end
            ST_CRC_LOW: begin
                if ((r_crc_low == r_crc[7:0]) && (i_byte == r_crc[15:8])) begin
                    done    = 1'b1;
                    n_state = ST_COMPLETE;
                end else begin
                    err     = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            default: begin
                // Waiting, a completed frame, or a code that is never reached.
                if (i_byte == i_slave_address) begin
                    n_crc        = crc_out;
                    n_exc        = 1'b0;
                    n_bytes_left = '0;
                    n_state      = ST_ADDR;
                end else if (r_state != ST_COMPLETE) begin
                    n_state = ST_WAIT;
                end
            end
        endcase

        n_result.frame_state    = n_state;
        n_result.frame_complete = done;
        n_result.crc_error      = err;
        // A bad CRC still reports the flag of the frame that just ended.
        n_result.is_exception   = n_exc;
        if (err) begin
            n_exc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_WAIT;
            r_bytes_left <= '0;
            r_crc        <= mrf_pkg::CRC_SEED;
            r_crc_low    <= '0;
            r_exc        <= 1'b0;
        end else if (i_step) begin
            r_state      <= n_state;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_crc_low    <= n_crc_low;
            r_exc        <= n_exc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== hw/rtl/modbus_rtu_response_framer_core.sv =====
// An accepted byte is held in the input register, then stepped into the result register, which drives its beat.
// Throughput: one byte per cycle while the result side is ready; the CRC update and state step are done together.
// An input register and a result register part the two sides. While a result beat
// waits, the input register still takes one byte, and then the input stalls.
// Reset (synchronous, active low) returns to waiting, seeds the CRC with 0xFFFF,
// empties both registers, holds off the input and sets the slave address to 1.
`default_nettype none
module modbus_rtu_response_framer_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [mrf_pkg::BYTE_W-1:0] i_cfg_wdata,
    mrf_rx_if.sink                          i_rx,
    mrf_res_if.source                       o_res
);

    logic [mrf_pkg::BYTE_W-1:0] r_slave_address;
    logic                       r_in_valid;
    logic [mrf_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_out_valid;
    logic                       step;
    mrf_pkg::t_result           result;

    // A held byte moves into the framer when the result register is free.
    assign step       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = i_rst_n && (!r_in_valid || step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= mrf_pkg::SLAVE_ADDR_RESET;
        end else if (i_cfg_we) begin
            r_slave_address <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    mrf_fsm u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_byte          (r_in_byte),
        .i_slave_address (r_slave_address),
        .o_result        (result)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.frame_state    = result.frame_state;
    assign o_res.frame_complete = result.frame_complete;
    assign o_res.crc_error      = result.crc_error;
    assign o_res.is_exception   = result.is_exception;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

    typedef enum logic [3:0] {
        FS_WAIT       = 4'd0,
        FS_ADDR       = 4'd1,
        FS_EXC_FUNC   = 4'd2,
        FS_EXC_CODE   = 4'd3,
        FS_READ_FUNC  = 4'd4,
        FS_WRITE_FUNC = 4'd5,
        FS_PAYLOAD    = 4'd6,
        FS_LAST       = 4'd7,
        FS_CRC_LOW    = 4'd8,
        FS_COMPLETE   = 4'd9
    } t_frame_state;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_PATTERN
    } t_ready_mode;

    // Low nibble of the function code, bit 7 clear.
    localparam logic [3:0] FN_READ_FIRST      = 4'd1;
    localparam logic [3:0] FN_READ_LAST       = 4'd4;
    localparam logic [3:0] FN_WRITE_COIL      = 4'd5;
    localparam logic [3:0] FN_WRITE_REG       = 4'd6;
    localparam logic [3:0] FN_WRITE_MULTI_COIL = 4'd15;
    localparam logic [3:0] FN_WRITE_MULTI_REG = 4'd0;
    localparam int         EXC_BIT            = 7;
    localparam int         WRITE_BODY_BYTES   = 4;

    localparam int CRC_FAULT_NONE = 0;
    localparam int CRC_FAULT_LOW  = 1;
    localparam int CRC_FAULT_HIGH = 2;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [mrf_pkg::BYTE_W-1:0] cfg_wdata;

    mrf_rx_if  rx_bus ();
    mrf_res_if res_bus ();

    modbus_rtu_response_framer_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_rx       (rx_bus),
        .o_res      (res_bus)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow of the framer state.
    t_frame_state              fr_state;
    logic [7:0]                fr_bytes_left;
    logic [mrf_pkg::CRC_W-1:0] fr_crc;
    logic [7:0]                fr_crc_low;
    logic                      fr_exc;
    logic [7:0]                slave_addr_shadow;

    logic [7:0]        pending_bytes[$];
    mrf_pkg::t_result  expected_results[$];
    mrf_pkg::t_result  exp_r;
    mrf_pkg::t_result  pred_r;
    int                mismatches = 0;

    logic rx_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;

    t_ready_mode ready_mode = RDY_ALWAYS;
    int   ready_count = 0;
    int   hold_left = 0;
    logic long_hold_go = 1'b0;
    logic long_hold_done = 1'b0;

    function automatic logic [mrf_pkg::CRC_W-1:0] crc16_byte(
        input logic [mrf_pkg::CRC_W-1:0] c, input logic [7:0] b);
        logic [mrf_pkg::CRC_W-1:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ mrf_pkg::CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic is_write_code(input logic [3:0] nib);
        return nib == FN_WRITE_COIL || nib == FN_WRITE_REG ||
               nib == FN_WRITE_MULTI_COIL || nib == FN_WRITE_MULTI_REG;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function void framer_reset();
        fr_state          = FS_WAIT;
        fr_bytes_left     = 8'd0;
        fr_crc            = mrf_pkg::CRC_SEED;
        fr_crc_low        = 8'd0;
        fr_exc            = 1'b0;
        slave_addr_shadow = mrf_pkg::SLAVE_ADDR_RESET;
    endfunction

    // Advances the shadow state by one received byte and returns the expected beat.
    function void frame_step(input logic [7:0] b, output mrf_pkg::t_result r);
        logic done;
        logic err;
        logic [3:0] nib;
        done = 1'b0;
        err  = 1'b0;
        nib  = b[3:0];
        case (fr_state)
            FS_ADDR: begin
                fr_crc = crc16_byte(fr_crc, b);
                if (b[EXC_BIT]) begin
                    fr_exc   = 1'b1;
                    fr_state = FS_EXC_FUNC;
                end else if (nib >= FN_READ_FIRST && nib <= FN_READ_LAST) begin
                    fr_exc   = 1'b0;
                    fr_state = FS_READ_FUNC;
                end else if (is_write_code(nib)) begin
                    fr_exc   = 1'b0;
                    fr_state = FS_WRITE_FUNC;
                end else begin
                    fr_exc   = 1'b0;
                    fr_state = FS_WAIT;
                end
            end
            FS_EXC_FUNC: begin
                fr_crc   = crc16_byte(fr_crc, b);
                fr_state = FS_EXC_CODE;
            end
            FS_EXC_CODE, FS_LAST: begin
                fr_crc_low = b;
                fr_state   = FS_CRC_LOW;
            end
            FS_READ_FUNC: begin
                fr_crc        = crc16_byte(fr_crc, b);
                fr_bytes_left = b;
                fr_state      = (b == 8'd0) ? FS_LAST : FS_PAYLOAD;
            end
            FS_WRITE_FUNC: begin
                fr_crc        = crc16_byte(fr_crc, b);
                fr_bytes_left = mrf_pkg::WRITE_BYTES_LEFT;
                fr_state      = FS_PAYLOAD;
            end
            FS_PAYLOAD: begin
                fr_crc        = crc16_byte(fr_crc, b);
                fr_bytes_left = fr_bytes_left - 8'd1;
                if (fr_bytes_left == 8'd0) begin
                    fr_state = FS_LAST;
                end
            end
            FS_CRC_LOW: begin
                if (fr_crc_low == fr_crc[7:0] && b == fr_crc[15:8]) begin
                    done     = 1'b1;
                    fr_state = FS_COMPLETE;
                end else begin
                    err      = 1'b1;
                    fr_state = FS_WAIT;
                end
            end
            default: begin
                // The complete state behaves like wait but holds on a foreign byte.
                if (b == slave_addr_shadow) begin
                    fr_crc        = crc16_byte(mrf_pkg::CRC_SEED, b);
                    fr_exc        = 1'b0;
                    fr_bytes_left = 8'd0;
                    fr_state      = FS_ADDR;
                end else if (fr_state != FS_COMPLETE) begin
                    fr_state = FS_WAIT;
                end
            end
        endcase
        r.frame_state    = fr_state;
        r.frame_complete = done;
        r.crc_error      = err;
        r.is_exception   = fr_exc;
        if (err) begin
            fr_exc = 1'b0;
        end
    endfunction

    task automatic check_field(input string what, input logic [3:0] exp_v,
                               input logic [3:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        end
    endtask

    // Input side: predict on every accepted beat.
    always @(posedge clk) begin
        rx_taken = rst_n && rx_bus.valid && rx_bus.ready;
        if (rx_taken) begin
            frame_step(rx_bus.rx_byte, pred_r);
            expected_results.push_back(pred_r);
        end
    end

    // Sender: bursts of random length with random gaps between them.
    always @(negedge clk) begin
        if (!rst_n) begin
            rx_bus.valid <= 1'b0;
        end else if (!rx_bus.valid || rx_taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                rx_bus.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                rx_bus.valid   <= 1'b1;
                rx_bus.rx_byte <= pending_bytes.pop_front();
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                rx_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: a randomly picked ready pattern, plus one long hold-off.
    always @(negedge clk) begin
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_bus.ready <= 1'b0;
        end else if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left      = 300;
            res_bus.ready <= 1'b0;
        end else begin
            case (ready_mode)
                RDY_ALWAYS:  res_bus.ready <= 1'b1;
                RDY_COIN:    res_bus.ready <= ($urandom_range(0, 1) == 1);
                RDY_MOSTLY:  res_bus.ready <= ($urandom_range(0, 3) != 0);
                default:     res_bus.ready <= (ready_count % 5 != 2);
            endcase
        end
        ready_count++;
        if (ready_count >= 40) begin
            ready_count = 0;
            ready_mode  = t_ready_mode'($urandom_range(0, 3));
        end
    end

    // Output side: compare each beat with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual state %0d",
                         $time, res_bus.frame_state);
            end else begin
                exp_r = expected_results.pop_front();
                check_field("frame_state", exp_r.frame_state, res_bus.frame_state);
                check_field("frame_complete", {3'b0, exp_r.frame_complete},
                            {3'b0, res_bus.frame_complete});
                check_field("crc_error", {3'b0, exp_r.crc_error}, {3'b0, res_bus.crc_error});
                check_field("is_exception", {3'b0, exp_r.is_exception},
                            {3'b0, res_bus.is_exception});
            end
        end
    end

    // Queues one frame with its CRC; an unknown function code ends it after that byte.
    task automatic push_frame(input logic [7:0] addr, input logic [7:0] func,
                              input int count, input int crc_fault, output int n);
        logic [7:0]                body[$];
        logic [mrf_pkg::CRC_W-1:0] c;
        logic [7:0]                lo;
        logic [7:0]                hi;
        body.push_back(addr);
        body.push_back(func);
        c = mrf_pkg::CRC_SEED;
        if (func[EXC_BIT]) begin
            body.push_back(rand_byte());
        end else if (func[3:0] >= FN_READ_FIRST && func[3:0] <= FN_READ_LAST) begin
            body.push_back(count[7:0]);
            repeat (count) body.push_back(rand_byte());
        end else if (is_write_code(func[3:0])) begin
            repeat (WRITE_BODY_BYTES) body.push_back(rand_byte());
        end else begin
            foreach (body[i]) pending_bytes.push_back(body[i]);
            n = body.size();
            return;
        end
        foreach (body[i]) begin
            c = crc16_byte(c, body[i]);
            pending_bytes.push_back(body[i]);
        end
        lo = c[7:0];
        hi = c[15:8];
        if (crc_fault == CRC_FAULT_LOW) begin
            lo = lo ^ 8'($urandom_range(1, 255));
        end else if (crc_fault == CRC_FAULT_HIGH) begin
            hi = hi ^ 8'($urandom_range(1, 255));
        end
        pending_bytes.push_back(lo);
        pending_bytes.push_back(hi);
        n = body.size() + 2;
    endtask

    task automatic random_frames(input int n_items);
        int added;
        int n;
        int pick;
        int fault;
        int count;
        logic [7:0] func;
        logic [3:0] write_codes[4];
        write_codes = '{FN_WRITE_COIL, FN_WRITE_REG, FN_WRITE_MULTI_COIL, FN_WRITE_MULTI_REG};
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // Line noise between frames.
                repeat ($urandom_range(1, 4)) pending_bytes.push_back(rand_byte());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    func = {1'b1, 7'($urandom_range(0, 127))};
                end else if (pick < 55) begin
                    func = {1'b0, 3'($urandom_range(0, 7)), 4'($urandom_range(1, 4))};
                end else if (pick < 90) begin
                    func = {1'b0, 3'($urandom_range(0, 7)), write_codes[$urandom_range(0, 3)]};
                end else begin
                    func = {1'b0, 3'($urandom_range(0, 7)), 4'($urandom_range(7, 14))};
                end
                pick  = $urandom_range(0, 99);
                fault = (pick < 8) ? CRC_FAULT_LOW :
                        (pick < 16) ? CRC_FAULT_HIGH : CRC_FAULT_NONE;
                count = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 255)
                                                     : $urandom_range(0, 6);
                push_frame(slave_addr_shadow, func, count, fault, n);
                added += n;
            end
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || rx_bus.valid || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_slave_addr(input logic [7:0] a);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(negedge clk);
        cfg_we    <= 1'b0;
        slave_addr_shadow = a;
    endtask

    initial begin
        int n;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = '0;
        res_bus.ready  = 1'b0;
        framer_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset address.
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        push_frame(mrf_pkg::SLAVE_ADDR_RESET, 8'h03, 2, CRC_FAULT_NONE, n);
        // A foreign byte right after a good frame must leave the complete state held.
        pending_bytes.push_back(8'h55);
        push_frame(mrf_pkg::SLAVE_ADDR_RESET, 8'h10, 0, CRC_FAULT_HIGH, n);
        push_frame(mrf_pkg::SLAVE_ADDR_RESET, 8'h83, 0, CRC_FAULT_NONE, n);
        push_frame(mrf_pkg::SLAVE_ADDR_RESET, 8'h04, 0, CRC_FAULT_NONE, n);
        push_frame(mrf_pkg::SLAVE_ADDR_RESET, 8'h07, 0, CRC_FAULT_NONE, n);
        push_frame(mrf_pkg::SLAVE_ADDR_RESET, 8'hFF, 0, CRC_FAULT_LOW, n);
        drain();

        write_slave_addr(8'h00);
        random_frames(300);
        @(posedge clk);
        long_hold_go = 1'b1;
        drain();

        write_slave_addr(8'hFF);
        random_frames(300);
        drain();

        write_slave_addr(rand_byte());
        random_frames(300);
        drain();

        write_slave_addr(rand_byte());
        random_frames(300);
        drain();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mrf_pkg.sv
hw/rtl/mrf_rx_if.sv
hw/rtl/mrf_res_if.sv
hw/rtl/mrf_crc.sv
hw/rtl/mrf_fsm.sv
hw/rtl/modbus_rtu_response_framer_core.sv
tb/tb_top.sv
